// ----- src/sbda_pkg.sv -----
`timescale 1ns / 1ps

package sbda_pkg;

  function automatic int dec_digits(input int bits);
    logic [63:0] v;
    int          n;
    v = 64'd1 << (bits - 1);
    n = 0;
    while (v != 64'd0) begin
      n++;
      v = v / 64'd10;
    end
    return n;
  endfunction

  localparam int VALUE_BITS   = 32;
  localparam int NUM_DIGITS   = dec_digits(VALUE_BITS);
  localparam int BCD_BITS     = 4 * NUM_DIGITS;
  localparam int CNT_BITS     = $clog2(VALUE_BITS);
  localparam int DIG_IDX_BITS = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int IN_BYTES     = (VALUE_BITS + 7) / 8;
  localparam int IN_DATA_BITS = 8 * IN_BYTES;
  localparam int CHAR_BITS    = 7;
  localparam int OUT_DATA_BITS = 8;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_SIGN,
    ST_DIGIT
  } sbda_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } dabble_ctrl_t;

endpackage

// ----- src/signed_binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps

// Converts one signed 32-bit value per input beat into its decimal ASCII text.
// Input channel: in_tdata carries the two's-complement value. Output channel:
// one beat per character, most significant first, with a leading '-' for a
// negative value, no leading zeros, and "0" for zero. out_tlast marks the
// final character of each value's text; no terminator is sent.
// After a beat is accepted the block converts the magnitude with a
// shift-and-add-3 unit, one binary bit per cycle. It then scans the digits
// from the top at one per cycle until the first nonzero one or the lowest
// digit, and sends one character per cycle while the receiver takes them.
// in_tready is high only while no conversion is in progress. A registered
// output stage holds the current character while the receiver stalls, and
// the sequencer waits on it; the next value can be accepted while the last
// character still waits. Reset clears the sequencer and the output valid;
// no value is in flight afterwards.
module signed_binary_to_decimal_ascii (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sbda_pkg::IN_DATA_BITS-1:0] in_tdata,   // [31:0] value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sbda_pkg::OUT_DATA_BITS-1:0] out_tdata, // [6:0] char_code, [7] zero
  output logic                              out_tlast   // last_char
);
  import sbda_pkg::*;

  localparam logic [CNT_BITS-1:0]     CNT_LAST = CNT_BITS'(VALUE_BITS - 1);
  localparam logic [DIG_IDX_BITS-1:0] IDX_TOP  = DIG_IDX_BITS'(NUM_DIGITS - 1);

  sbda_state_t state_r, state_nxt;
  logic [CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic [DIG_IDX_BITS-1:0] idx_r, idx_nxt;
  logic                    neg_r, neg_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0]    char_r, char_nxt;
  logic                    last_r, last_nxt;

  dabble_ctrl_t            dd_ctrl;
  logic [VALUE_BITS-1:0]   raw;
  logic [VALUE_BITS-1:0]   mag;
  logic [BCD_BITS-1:0]     bcd;
  logic [3:0]              digit;
  logic                    in_beat;
  logic                    out_free;

  assign raw      = in_tdata[VALUE_BITS-1:0];
  assign mag      = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign digit    = bcd[idx_r*4 +: 4];
  assign in_beat  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  sbda_dabble u_dabble (
    .clk  (clk),
    .ctrl (dd_ctrl),
    .mag  (mag),
    .bcd  (bcd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_TRIM;
      end
      ST_TRIM: begin
        if (digit != 4'd0 || idx_r == '0) state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (out_free) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_free && idx_r == '0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    dd_ctrl       = '0;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    char_nxt      = char_r;
    last_nxt      = last_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        dd_ctrl.load = in_tvalid;
        cnt_nxt      = '0;
        if (in_tvalid) neg_nxt = raw[VALUE_BITS-1];
      end
      ST_CONV: begin
        dd_ctrl.step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        idx_nxt      = IDX_TOP;
      end
      ST_TRIM: begin
        if (digit == 4'd0 && idx_r != '0) idx_nxt = idx_r - 1'b1;
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = CHAR_MINUS;
          last_nxt      = 1'b0;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = CHAR_ZERO + {3'b000, digit};
          last_nxt      = (idx_r == '0);
          if (idx_r != '0) idx_nxt = idx_r - 1'b1;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, char_r};
  assign out_tlast  = last_r;

`ifndef NO_ASSERTIONS
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("input accepted while a conversion was starting");

  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[6:0] >= CHAR_ZERO &&
                                out_tdata[6:0] <= CHAR_ZERO + 7'd9)
    else $error("final character is not a digit");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6:0] == CHAR_MINUS |-> !out_tlast)
    else $error("minus sign marked as final character");

  a_no_emit_while_converting: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV && !out_valid_r |=> !out_valid_r)
    else $error("character sent during conversion");
`endif

endmodule

// ----- src/sbda_dabble.sv -----
`timescale 1ns / 1ps

module sbda_dabble (
  input  logic                           clk,
  input  sbda_pkg::dabble_ctrl_t         ctrl,
  input  logic [sbda_pkg::VALUE_BITS-1:0] mag,
  output logic [sbda_pkg::BCD_BITS-1:0]   bcd
);
  import sbda_pkg::*;

  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_BITS-1:0]   bcd_r, bcd_nxt;
  logic [BCD_BITS-1:0]   adj;

  // Each step corrects every BCD column above four, then shifts one binary bit in.
  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctrl.load) begin
      bin_nxt = mag;
      bcd_nxt = '0;
    end else if (ctrl.step) begin
      bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt = {adj[BCD_BITS-2:0], bin_r[VALUE_BITS-1]};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd = bcd_r;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sbda_pkg::*;

  typedef struct packed {
    logic [CHAR_BITS-1:0] code;
    logic                 last;
  } char_beat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [2:0]            gap;
    logic                  wait_idle;
  } num_item_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tlast;

  num_item_t  num_q[$];
  char_beat_t text_q[$];
  num_item_t  cur_num;
  char_beat_t want;
  int         gap_left = 0;
  int         stall_left = 0;
  int         n_in = 0;
  int         n_out = 0;
  int         n_total = 0;
  int         fail_count = 0;
  logic       rx_hold = 1'b0;

  signed_binary_to_decimal_ascii i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Appends the expected characters of one value's decimal text.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            dig [0:NUM_DIGITS-1];
    int                    nd;
    int                    total;
    int                    k;
    neg = value[VALUE_BITS-1];
    mag = neg ? (~value + 1'b1) : value;
    nd = 0;
    do begin
      dig[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0);
    total = nd + (neg ? 1 : 0);
    k = 0;
    if (neg) begin
      text_q.push_back('{code: CHAR_MINUS, last: (k == total - 1)});
      k++;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      text_q.push_back('{code: CHAR_ZERO + CHAR_BITS'(dig[i]), last: (k == total - 1)});
      k++;
    end
  endfunction

  function automatic void add_num(input logic [VALUE_BITS-1:0] value, input int gap,
                                  input logic wait_idle);
    num_q.push_back('{value: value, gap: 3'(gap), wait_idle: wait_idle});
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata[VALUE_BITS-1:0]);
        n_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (num_q.size() != 0 && !(num_q[0].wait_idle && text_q.size() != 0)) begin
          cur_num = num_q.pop_front();
          in_tdata  <= cur_num.value;
          in_tvalid <= 1'b1;
          gap_left = cur_num.gap;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_out++;
        if (text_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected char beat: code %0d last %0b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = text_q.pop_front();
          if (out_tdata != {1'b0, want.code} || out_tlast != want.last) begin
            if (fail_count < 10)
              $display("char beat %0d: expected code %0d last %0b, got tdata %0d last %0b",
                       n_out, want.code, want.last, out_tdata, out_tlast);
            fail_count++;
          end
        end
        stall_left = $urandom_range(0, ((n_out / 50) % 3 == 2) ? 0 : 4);
      end
      if (rx_hold || stall_left > 0) begin
        if (stall_left > 0)
          stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // The receiver stops for a long stretch while the sender keeps offering values.
  initial begin
    while (n_in < 60)
      @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] p;
    int                    r;
    int                    g;
    add_num(32'd0, 0, 1'b0);
    add_num(32'd1, 1, 1'b0);
    add_num(-32'sd1, 0, 1'b0);
    add_num(32'd9, 4, 1'b0);
    add_num(32'd10, 0, 1'b0);
    add_num(-32'sd10, 2, 1'b0);
    add_num(32'd99, 0, 1'b0);
    add_num(32'd100, 3, 1'b0);
    add_num(32'h7FFF_FFFF, 0, 1'b0);
    add_num(32'h8000_0000, 0, 1'b0);
    add_num(32'h8000_0001, 1, 1'b0);
    add_num(32'd1000000000, 0, 1'b0);
    add_num(32'd999999999, 0, 1'b0);
    add_num(-32'sd999999999, 2, 1'b0);
    add_num(-32'sd1000000000, 0, 1'b0);
    add_num(32'd1234567890, 0, 1'b0);
    add_num(32'h5555_5555, 4, 1'b0);
    add_num(32'hAAAA_AAAA, 0, 1'b0);
    add_num(32'd7, 0, 1'b0);
    add_num(-32'sd5, 1, 1'b0);
    for (int i = 0; i < 200; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1)
          v = -v;
      end else if (r < 9) begin
        v = $urandom;
      end else begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1)
          v = -v;
      end
      g = (i >= 40 && i < 100) || (i >= 160 && i < 180) ? 0 : $urandom_range(0, 4);
      add_num(v, g, (i == 0 || i == 130));
    end
    n_total = num_q.size();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (n_in < n_total)
      @(posedge clk);
    while (text_q.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && text_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("tb failed");
    $finish;
  end

endmodule
